/* hdl/lir_pkg.sv */
// ----------------------------------------------------------------------------
// lir_pkg
// Shared types, constants and helpers of the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

    localparam int MAX_FRAME_LEN = 2048;
    localparam int MAX_RESULTS   = 32;
    localparam int QUEUE_DEPTH   = 4;
    localparam int SAMPLE_W      = 16;
    localparam int RATE_W        = 17;
    localparam int CHAN_W        = 2;
    localparam int REG_IDX_W     = 2;

    localparam logic [RATE_W-1:0] RATE_MIN       = 17'd8000;
    localparam logic [RATE_W-1:0] RATE_MAX       = 17'd96000;
    localparam logic [RATE_W-1:0] IN_RATE_RESET  = 17'd44100;
    localparam logic [RATE_W-1:0] OUT_RATE_RESET = 17'd48000;
    localparam logic [CHAN_W-1:0] CHAN_RESET     = 2'd2;
    localparam logic [CHAN_W-1:0] CHAN_MONO      = 2'd1;

    localparam logic [REG_IDX_W-1:0] REG_INPUT_RATE    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_OUTPUT_RATE   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    typedef struct packed {
        logic [RATE_W-1:0] rin;
        logic [RATE_W-1:0] rout;
        logic              mono;
    } cfg_t;

    typedef struct packed {
        logic                       pass;
        logic                       frame_end;
        logic signed [SAMPLE_W-1:0] right;
        logic signed [SAMPLE_W-1:0] left;
    } item_t;

    function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
        logic [RATE_W-1:0] v;
        if (r < RATE_MIN) begin
            v = RATE_MIN;
        end else if (r > RATE_MAX) begin
            v = RATE_MAX;
        end else begin
            v = r;
        end
        return v;
    endfunction

endpackage

/* hdl/lir_front.sv */
// ----------------------------------------------------------------------------
// lir_front
// Input side: takes sample frames, tags pass-through, zeroes right in mono, queues them.
// ----------------------------------------------------------------------------
module lir_front #(
    parameter int DEPTH = lir_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lir_pkg::cfg_t        cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // left_sample [15:0], right_sample [31:16]
    input  logic                 s_tlast,   // frame_end
    output lir_pkg::item_t       q_item,
    output logic                 q_valid,
    input  logic                 q_pop
);
    import lir_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    item_t          mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [NW-1:0]  fill_reg;
    item_t          in_item;
    logic           push;
    logic           pop;

    assign s_tready = (fill_reg != NW'(DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        in_item.pass      = (cfg.rin == cfg.rout);
        in_item.frame_end = s_tlast;
        in_item.left      = s_tdata[15:0];
        in_item.right     = cfg.mono ? '0 : s_tdata[31:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                mem_reg[wr_ptr_reg] <= in_item;
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

/* hdl/lir_div.sv */
// ----------------------------------------------------------------------------
// lir_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lir_div #(
    parameter int NW = 35,
    parameter int DW = 18,
    parameter int QW = 17
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [QW-1:0] quot
);
    localparam int SW = $clog2(QW + 1);

    logic [DW-1:0] rem_reg;
    logic [QW-1:0] sh_reg;
    logic [SW-1:0] step_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;

    // caller guarantees the quotient fits in QW bits
    assign trial = {rem_reg, sh_reg[QW-1]};
    assign ge    = (trial >= {1'b0, den});
    assign diff  = trial - {1'b0, den};
    assign done  = done_reg;
    assign quot  = sh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= DW'(num[NW-1:QW]);
                sh_reg   <= num[QW-1:0];
                step_reg <= SW'(QW);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                sh_reg   <= {sh_reg[QW-2:0], ge};
                step_reg <= step_reg - 1'b1;
                if (step_reg == SW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* hdl/lir_core.sv */
// ----------------------------------------------------------------------------
// lir_core
// Back end: position stepping, interpolation, end-of-frame repeats, output.
// ----------------------------------------------------------------------------
module lir_core #(
    parameter int MAX_FRAME_LEN = lir_pkg::MAX_FRAME_LEN
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  lir_pkg::cfg_t    cfg,
    input  lir_pkg::item_t   q_item,
    input  logic             q_valid,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,   // left_out [15:0], right_out [31:16]
    output logic             m_tlast    // run_last
);
    import lir_pkg::*;

    localparam int IW    = $clog2(MAX_FRAME_LEN + 1);
    localparam int PW    = IW + 5;
    localparam int CW    = IW + 5;
    localparam int PHW   = RATE_W + 1;
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);
    localparam int AW    = ((CW + RATE_W) > 32 ? (CW + RATE_W) : 32) + 2;
    localparam int NUM_W = 36;
    localparam int MAG_W = NUM_W - 1;
    localparam int DEN_W = RATE_W + 1;
    localparam int Q_W   = 17;
    localparam int SW    = SAMPLE_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_NORM, ST_CHECK, ST_MUL, ST_SUM, ST_DIV, ST_EMIT, ST_RED,
        ST_ADV, ST_ENDM, ST_ENDA, ST_ENDX, ST_REP, ST_FLUSH
    } state_t;

    state_t                   state_reg;
    logic signed [SW-1:0]     x_l_reg, x_r_reg, prev_l_reg, prev_r_reg;
    logic                     x_end_reg;
    logic [IW-1:0]            index_reg;
    logic [PW-1:0]            pos_reg;
    logic [PHW-1:0]           phase_reg;
    logic [CW-1:0]            count_reg;
    logic signed [SW-1:0]     last_l_reg, last_r_reg;
    logic signed [31:0]       carry_reg;
    logic [CNT_W-1:0]         cnt_reg, rep_reg;
    logic                     hold_valid_reg;
    logic signed [SW-1:0]     hold_l_reg, hold_r_reg;
    logic                     out_valid_reg, out_last_reg;
    logic signed [SW-1:0]     out_l_reg, out_r_reg;
    logic signed [34:0]       pl_l_reg, pl_r_reg;
    logic signed [33:0]       al_l_reg, al_r_reg;
    logic [MAG_W-1:0]         mag_l_reg, mag_r_reg;
    logic                     neg_l_reg, neg_r_reg;
    logic                     div_start_reg;
    logic [IW+RATE_W-1:0]     p1_reg;
    logic [CW+RATE_W-1:0]     p2_reg;
    logic signed [AW-1:0]     acc_reg;

    logic [IW-1:0]            index_inc;
    logic                     group_end;
    logic                     out_free;
    logic                     phase_big;
    logic signed [NUM_W-1:0]  n_l, n_r, nm_l, nm_r;
    logic [Q_W-1:0]           q_l, q_r;
    logic                     done_l, done_r;
    logic signed [SW-1:0]     res_l, res_r;
    logic signed [RATE_W:0]   rout_s;

    function automatic logic signed [SW-1:0] fold(input logic [Q_W-1:0] q, input logic neg);
        logic signed [Q_W:0] v;
        logic signed [SW-1:0] r;
        v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (v > (Q_W+1)'(32767)) begin
            r = 16'sh7FFF;
        end else if (v < -(Q_W+1)'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    assign index_inc = index_reg + 1'b1;
    assign group_end = x_end_reg || (index_inc >= IW'(MAX_FRAME_LEN));
    assign out_free  = !out_valid_reg || m_tready;
    assign phase_big = (phase_reg >= {1'b0, cfg.rout});
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign rout_s    = $signed({1'b0, cfg.rout});

    // numerator 2*a*r + 2*p*(b-a) + r, then sign and magnitude for the divider
    assign n_l  = (NUM_W'(al_l_reg) <<< 1) + (NUM_W'(pl_l_reg) <<< 1) + NUM_W'(rout_s);
    assign n_r  = (NUM_W'(al_r_reg) <<< 1) + (NUM_W'(pl_r_reg) <<< 1) + NUM_W'(rout_s);
    assign nm_l = n_l[NUM_W-1] ? -n_l : n_l;
    assign nm_r = n_r[NUM_W-1] ? -n_r : n_r;

    assign res_l = fold(q_l, neg_l_reg);
    assign res_r = cfg.mono ? '0 : fold(q_r, neg_r_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_r_reg, out_l_reg};
    assign m_tlast  = out_last_reg;

    lir_div #(.NW(MAG_W), .DW(DEN_W), .QW(Q_W)) u_div_l (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg), .num(mag_l_reg),
        .den({cfg.rout, 1'b0}), .done(done_l), .quot(q_l)
    );

    lir_div #(.NW(MAG_W), .DW(DEN_W), .QW(Q_W)) u_div_r (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg), .num(mag_r_reg),
        .den({cfg.rout, 1'b0}), .done(done_r), .quot(q_r)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            prev_l_reg     <= '0;
            prev_r_reg     <= '0;
            index_reg      <= '0;
            pos_reg        <= '0;
            phase_reg      <= '0;
            count_reg      <= '0;
            last_l_reg     <= '0;
            last_r_reg     <= '0;
            carry_reg      <= '0;
            cnt_reg        <= '0;
            rep_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
            div_start_reg  <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        x_l_reg   <= q_item.left;
                        x_r_reg   <= q_item.right;
                        x_end_reg <= q_item.frame_end;
                        cnt_reg   <= '0;
                        if (q_item.pass) begin
                            hold_valid_reg <= 1'b1;
                            hold_l_reg     <= q_item.left;
                            hold_r_reg     <= q_item.right;
                            prev_l_reg     <= q_item.left;
                            prev_r_reg     <= q_item.right;
                            last_l_reg     <= q_item.left;
                            last_r_reg     <= q_item.right;
                            if (q_item.frame_end || index_inc >= IW'(MAX_FRAME_LEN)) begin
                                index_reg <= '0;
                                pos_reg   <= '0;
                                phase_reg <= '0;
                                count_reg <= '0;
                            end else begin
                                index_reg <= index_inc;
                            end
                            state_reg <= ST_FLUSH;
                        end else begin
                            state_reg <= ST_NORM;
                        end
                    end
                end
                ST_NORM, ST_RED: begin
                    // whole steps of the phase move into the position
                    if (phase_big) begin
                        phase_reg <= phase_reg - {1'b0, cfg.rout};
                        pos_reg   <= pos_reg + 1'b1;
                    end else begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (index_reg != '0 && pos_reg < PW'(index_reg)
                            && cnt_reg < CNT_W'(MAX_RESULTS)) begin
                        state_reg <= ST_MUL;
                    end else begin
                        state_reg <= ST_ADV;
                    end
                end
                ST_MUL: begin
                    pl_l_reg  <= $signed({1'b0, phase_reg[RATE_W-1:0]})
                               * ((SW+1)'(x_l_reg) - (SW+1)'(prev_l_reg));
                    pl_r_reg  <= $signed({1'b0, phase_reg[RATE_W-1:0]})
                               * ((SW+1)'(x_r_reg) - (SW+1)'(prev_r_reg));
                    al_l_reg  <= prev_l_reg * rout_s;
                    al_r_reg  <= prev_r_reg * rout_s;
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    neg_l_reg     <= n_l[NUM_W-1];
                    neg_r_reg     <= n_r[NUM_W-1];
                    mag_l_reg     <= nm_l[MAG_W-1:0];
                    mag_r_reg     <= nm_r[MAG_W-1:0];
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_DIV;
                end
                ST_DIV: begin
                    if (done_l && done_r) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!hold_valid_reg || out_free) begin
                        if (hold_valid_reg) begin
                            out_valid_reg <= 1'b1;
                            out_l_reg     <= hold_l_reg;
                            out_r_reg     <= hold_r_reg;
                            out_last_reg  <= 1'b0;
                        end
                        hold_valid_reg <= 1'b1;
                        hold_l_reg     <= res_l;
                        hold_r_reg     <= res_r;
                        last_l_reg     <= res_l;
                        last_r_reg     <= res_r;
                        cnt_reg        <= cnt_reg + 1'b1;
                        count_reg      <= count_reg + 1'b1;
                        phase_reg      <= phase_reg + {1'b0, cfg.rin};
                        state_reg      <= ST_RED;
                    end
                end
                ST_ADV: begin
                    prev_l_reg <= x_l_reg;
                    prev_r_reg <= x_r_reg;
                    if (group_end && count_reg != '0) begin
                        index_reg <= index_inc;
                        state_reg <= ST_ENDM;
                    end else if (group_end) begin
                        index_reg <= '0;
                        pos_reg   <= '0;
                        phase_reg <= '0;
                        count_reg <= '0;
                        state_reg <= ST_FLUSH;
                    end else begin
                        index_reg <= index_inc;
                        state_reg <= ST_FLUSH;
                    end
                end
                ST_ENDM: begin
                    p1_reg    <= index_reg * cfg.rout;
                    p2_reg    <= count_reg * cfg.rin;
                    state_reg <= ST_ENDA;
                end
                ST_ENDA: begin
                    acc_reg   <= AW'($signed({1'b0, p1_reg})) - AW'($signed({1'b0, p2_reg}))
                               + AW'(carry_reg);
                    rep_reg   <= '0;
                    state_reg <= ST_ENDX;
                end
                ST_ENDX: begin
                    // whole missing outputs, limited by the room left in this transaction run
                    if (acc_reg >= AW'($signed({1'b0, cfg.rin}))
                            && cnt_reg < CNT_W'(MAX_RESULTS)) begin
                        acc_reg <= acc_reg - AW'($signed({1'b0, cfg.rin}));
                        rep_reg <= rep_reg + 1'b1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end else begin
                        if (acc_reg > AW'(32'sh7FFF_FFFF)) begin
                            carry_reg <= 32'sh7FFF_FFFF;
                        end else if (acc_reg < AW'(32'sh8000_0000)) begin
                            carry_reg <= 32'sh8000_0000;
                        end else begin
                            carry_reg <= acc_reg[31:0];
                        end
                        index_reg <= '0;
                        pos_reg   <= '0;
                        phase_reg <= '0;
                        count_reg <= '0;
                        state_reg <= ST_REP;
                    end
                end
                ST_REP: begin
                    if (rep_reg == '0) begin
                        state_reg <= ST_FLUSH;
                    end else if (!hold_valid_reg || out_free) begin
                        if (hold_valid_reg) begin
                            out_valid_reg <= 1'b1;
                            out_l_reg     <= hold_l_reg;
                            out_r_reg     <= hold_r_reg;
                            out_last_reg  <= 1'b0;
                        end
                        hold_valid_reg <= 1'b1;
                        hold_l_reg     <= last_l_reg;
                        hold_r_reg     <= last_r_reg;
                        rep_reg        <= rep_reg - 1'b1;
                    end
                end
                ST_FLUSH: begin
                    // the held result is the last one of this input
                    if (!hold_valid_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        out_valid_reg  <= 1'b1;
                        out_l_reg      <= hold_l_reg;
                        out_r_reg      <= hold_r_reg;
                        out_last_reg   <= 1'b1;
                        hold_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/linear_interp_resampler.sv */
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Linear interpolation sample rate converter for 16-bit mono/stereo PCM.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                         tlast
//  s_        in         left_sample, right_sample     frame_end
//  m_        out        left_out, right_out           run_last
//  cfg_      in         write enable, index, data     -
//
//  equal rates: each input passes through as one result
//  otherwise each result takes up to 12 phase reduction steps and then
//  one division in each of the two 17-bit dividers, left and right
//  end of frame may add repeats of the last result
//  reset is synchronous and clears all frame state; a queue of QUEUE_DEPTH
//  items and one held output register decouple the two stream sides
// ----------------------------------------------------------------------------
module linear_interp_resampler #(
    parameter int MAX_FRAME_LEN = lir_pkg::MAX_FRAME_LEN,
    parameter int QUEUE_DEPTH   = lir_pkg::QUEUE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lir_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [lir_pkg::RATE_W-1:0]      cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,  // left_sample [15:0], right_sample [31:16]
    input  logic                            s_tlast,  // frame_end
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,  // left_out [15:0], right_out [31:16]
    output logic                            m_tlast   // run_last
);
    import lir_pkg::*;

    logic [RATE_W-1:0] in_rate_reg;
    logic [RATE_W-1:0] out_rate_reg;
    logic [CHAN_W-1:0] chan_reg;
    cfg_t              cfg;
    item_t             q_item;
    logic              q_valid;
    logic              q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_rate_reg  <= IN_RATE_RESET;
            out_rate_reg <= OUT_RATE_RESET;
            chan_reg     <= CHAN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_INPUT_RATE:    in_rate_reg  <= cfg_wr_data;
                REG_OUTPUT_RATE:   out_rate_reg <= cfg_wr_data;
                REG_CHANNEL_COUNT: chan_reg     <= cfg_wr_data[CHAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.rin  = clamp_rate(in_rate_reg);
        cfg.rout = clamp_rate(out_rate_reg);
        cfg.mono = (chan_reg == CHAN_MONO);
    end

    lir_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
    );

    lir_core #(.MAX_FRAME_LEN(MAX_FRAME_LEN)) u_core (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg),
        .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

endmodule
